/* rtl/byte_ring_buffer_chunked_unit_assert.svh */
// Assertion macros for the byte ring buffer
`ifndef BYTE_RING_BUFFER_CHUNKED_UNIT_ASSERT_SVH
`define BYTE_RING_BUFFER_CHUNKED_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BRB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("brb assertion failed");
`define BRB_ASSERT_NEVER(lbl, clk, rst, prop) \
  `BRB_ASSERT(lbl, clk, rst, !(prop))
`else
`define BRB_ASSERT(lbl, clk, rst, prop)
`define BRB_ASSERT_NEVER(lbl, clk, rst, prop)
`endif
`endif

/* rtl/brb_pkg.sv */
// Shared types and constants of the byte ring buffer
`default_nettype none
package brb_pkg;
  localparam int OP_W          = 2;
  localparam int LEN_W         = 4;
  localparam int DATA_W        = 64;
  localparam int FILL_W        = 11;
  localparam int CAP_W         = 11;
  localparam int BYTE_W        = 8;
  localparam int MAX_LANES     = 8;
  localparam int LANE_IDX_W    = 3;
  localparam int DEPTH_DEFAULT = 1024;
  localparam int LANES_DEFAULT = 8;
  localparam int CAP_RESET     = 1024;
  localparam int ROWS_DEFAULT  = 128;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2
  } op_t;

  typedef struct packed {
    logic                  wr;
    logic                  rd;
    logic [LANE_IDX_W-1:0] lane;
    logic [LEN_W-1:0]      len;
  } lane_req_t;

  typedef struct packed {
    logic                  ok;
    logic                  rd;
    logic [LANE_IDX_W-1:0] lane;
    logic [LEN_W-1:0]      len;
    logic [FILL_W-1:0]     fill;
  } rsp_meta_t;
endpackage
`default_nettype wire

/* rtl/byte_ring_buffer_chunked_unit.sv */
// Top level of the chunked byte ring buffer
//
//   channel | signals                          | direction
//   in      | in_valid in_stall op length data_in | item in, stall out
//   out     | out_valid out_stall accepted data_out fill_level | item out
//   cfg     | cfg_valid cfg_ready capacity     | write of capacity
//
// One item per cycle unless in_stall is high; results come from the merge register
// (banks and s1 load at the accepting edge, the merge register while take is high).
// Eight byte lanes, each with its own bank, serve a chunk in one access.
// Reset and a capacity write clear pointers and count; no clearing pass.
// in_stall rises only while both pipeline registers are full and out_stall is high.
`default_nettype none
`include "byte_ring_buffer_chunked_unit_assert.svh"
module byte_ring_buffer_chunked_unit #(
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT,
  parameter int LANES = brb_pkg::LANES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [brb_pkg::OP_W-1:0]      op,
  input  wire logic [brb_pkg::LEN_W-1:0]     length,
  input  wire logic [brb_pkg::DATA_W-1:0]    data_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               accepted,
  output logic [brb_pkg::DATA_W-1:0]         data_out,
  output logic [brb_pkg::FILL_W-1:0]         fill_level,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [brb_pkg::CAP_W-1:0]     capacity
);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ROWS     = (DEPTH + LANES - 1) / LANES;
  localparam int ROW_W    = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int CMP_W    = CNT_W > brb_pkg::CAP_W ? CNT_W : brb_pkg::CAP_W;
  localparam int CAP_INIT = brb_pkg::CAP_RESET > DEPTH ? DEPTH : brb_pkg::CAP_RESET;
  localparam int LIW      = brb_pkg::LANE_IDX_W;
  localparam int LEN_W    = brb_pkg::LEN_W;

  logic [CNT_W-1:0]   cap;
  logic [CNT_W-1:0]   count;
  logic [ROW_W-1:0]   wp_row;
  logic [LIW-1:0]     wp_lane;
  logic [ROW_W-1:0]   rp_row;
  logic [LIW-1:0]     rp_lane;
  logic               s1_valid;
  brb_pkg::rsp_meta_t s1_meta;

  logic               take;
  logic               acc;
  logic               is_wr;
  logic               is_rm;
  logic               is_rd;
  logic               ok;
  logic [CNT_W:0]     len_ext;
  logic [CNT_W:0]     cnt_ext;
  logic [CNT_W-1:0]   fill_next;
  logic [ROW_W-1:0]   base_row;
  logic [ROW_W-1:0]   row_inc;
  logic [LIW-1:0]     base_lane;
  logic [LEN_W-1:0]   lane_sum;
  logic [ROW_W-1:0]   row_next;
  logic [LIW-1:0]     lane_next;
  logic [CMP_W-1:0]   cap_in;
  logic [CNT_W-1:0]   cap_clamp;
  brb_pkg::lane_req_t req;
  brb_pkg::rsp_meta_t meta_next;
  logic [LANES*brb_pkg::BYTE_W-1:0] rbytes;

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid & ~take;
  assign acc       = in_valid & ~in_stall;

  always_comb begin
    is_wr   = op == brb_pkg::OP_WRITE;
    is_rm   = op == brb_pkg::OP_READ;
    is_rd   = is_rm || (op == brb_pkg::OP_PEEK);
    len_ext = (CNT_W + 1)'(length);
    cnt_ext = (CNT_W + 1)'(count);
    ok = (length <= LEN_W'(LANES)) &&
         ((is_wr && (cap != '0) && (cnt_ext + len_ext <= (CNT_W + 1)'(cap))) ||
          (is_rd && (len_ext <= cnt_ext)));
    if (ok && is_wr) begin
      fill_next = CNT_W'(cnt_ext + len_ext);
    end else if (ok && is_rm) begin
      fill_next = CNT_W'(cnt_ext - len_ext);
    end else begin
      fill_next = count;
    end

    base_row  = is_wr ? wp_row : rp_row;
    base_lane = is_wr ? wp_lane : rp_lane;
    row_inc   = (base_row == ROW_W'(ROWS - 1)) ? '0 : base_row + 1'b1;
    lane_sum  = LEN_W'(base_lane) + length;
    if (lane_sum >= LEN_W'(LANES)) begin
      lane_next = LIW'(lane_sum - LEN_W'(LANES));
      row_next  = row_inc;
    end else begin
      lane_next = lane_sum[LIW-1:0];
      row_next  = base_row;
    end

    req.wr   = acc & ok & is_wr;
    req.rd   = acc & ok & is_rd;
    req.lane = base_lane;
    req.len  = length;

    meta_next.ok   = ok;
    meta_next.rd   = is_rd;
    meta_next.lane = base_lane;
    meta_next.len  = length;
    meta_next.fill = brb_pkg::FILL_W'(fill_next);

    cap_in    = CMP_W'(capacity);
    cap_clamp = (cap_in > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap      <= CNT_W'(CAP_INIT);
      count    <= '0;
      wp_row   <= '0;
      wp_lane  <= '0;
      rp_row   <= '0;
      rp_lane  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap     <= cap_clamp;
        count   <= '0;
        wp_row  <= '0;
        wp_lane <= '0;
        rp_row  <= '0;
        rp_lane <= '0;
      end else if (acc && ok) begin
        count <= fill_next;
        if (is_wr) begin
          wp_row  <= row_next;
          wp_lane <= lane_next;
        end
        if (is_rm) begin
          rp_row  <= row_next;
          rp_lane <= lane_next;
        end
      end
      if (!in_stall) begin
        s1_valid <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_meta <= meta_next;
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    brb_lane #(
      .LANE_ID(j),
      .LANES  (LANES),
      .ROWS   (ROWS),
      .ROW_W  (ROW_W)
    ) u_lane (
      .clk    (clk),
      .req    (req),
      .row    (base_row),
      .row_inc(row_inc),
      .wbytes (data_in),
      .rbyte  (rbytes[j*brb_pkg::BYTE_W +: brb_pkg::BYTE_W])
    );
  end

  brb_merge #(
    .LANES(LANES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .meta      (s1_meta),
    .rbytes    (rbytes),
    .out_stall (out_stall),
    .take      (take),
    .out_valid (out_valid),
    .accepted  (accepted),
    .data_out  (data_out),
    .fill_level(fill_level)
  );

  `BRB_ASSERT(a_count_le_cap, clk, rst, count <= cap)
  `BRB_ASSERT(a_acc_fills_s1, clk, rst, acc |=> s1_valid)
  `BRB_ASSERT_NEVER(a_refused_data, clk, rst, out_valid && !accepted && (data_out != '0))
endmodule
`default_nettype wire

/* rtl/brb_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module brb_ram #(
  parameter int WIDTH = brb_pkg::BYTE_W,
  parameter int DEPTH = brb_pkg::ROWS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* rtl/brb_lane.sv */
// One byte lane: picks its byte of the chunk and owns one storage bank
`default_nettype none
module brb_lane #(
  parameter int LANE_ID = 0,
  parameter int LANES   = brb_pkg::LANES_DEFAULT,
  parameter int ROWS    = brb_pkg::ROWS_DEFAULT,
  parameter int ROW_W   = 7
) (
  input  wire logic                          clk,
  input  wire brb_pkg::lane_req_t            req,
  input  wire logic [ROW_W-1:0]              row,
  input  wire logic [ROW_W-1:0]              row_inc,
  input  wire logic [brb_pkg::DATA_W-1:0]    wbytes,
  output logic      [brb_pkg::BYTE_W-1:0]    rbyte
);
  localparam logic [brb_pkg::LEN_W-1:0] ID_V = brb_pkg::LEN_W'(LANE_ID);

  logic [brb_pkg::LEN_W-1:0]  idx;
  logic                       same_row;
  logic                       hit;
  logic [ROW_W-1:0]           addr;
  logic [brb_pkg::BYTE_W-1:0] wbyte;

  // position of this lane's byte within the chunk
  always_comb begin
    same_row = ID_V >= brb_pkg::LEN_W'(req.lane);
    if (same_row) begin
      idx = ID_V - brb_pkg::LEN_W'(req.lane);
    end else begin
      idx = ID_V + brb_pkg::LEN_W'(LANES) - brb_pkg::LEN_W'(req.lane);
    end
    hit   = idx < req.len;
    addr  = same_row ? row : row_inc;
    wbyte = wbytes[{idx[brb_pkg::LANE_IDX_W-1:0], 3'b000} +: brb_pkg::BYTE_W];
  end

  brb_ram #(
    .WIDTH(brb_pkg::BYTE_W),
    .DEPTH(ROWS)
  ) u_bank (
    .clk  (clk),
    .we   (req.wr & hit),
    .waddr(addr),
    .wdata(wbyte),
    .re   (req.rd & hit),
    .raddr(addr),
    .rdata(rbyte)
  );
endmodule
`default_nettype wire

/* rtl/brb_merge.sv */
// Merge stage: rotates lane bytes into order and holds the result register
`default_nettype none
module brb_merge #(
  parameter int LANES = brb_pkg::LANES_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s1_valid,
  input  wire brb_pkg::rsp_meta_t                 meta,
  input  wire logic [LANES*brb_pkg::BYTE_W-1:0]   rbytes,
  input  wire logic                               out_stall,
  output logic                                    take,
  output logic                                    out_valid,
  output logic                                    accepted,
  output logic [brb_pkg::DATA_W-1:0]              data_out,
  output logic [brb_pkg::FILL_W-1:0]              fill_level
);
  localparam int SEL_W = LANES > 1 ? $clog2(LANES) : 1;

  logic [brb_pkg::BYTE_W-1:0] rb [LANES];
  logic [brb_pkg::DATA_W-1:0] data_next;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      rb[j] = rbytes[j*brb_pkg::BYTE_W +: brb_pkg::BYTE_W];
    end
  end

  always_comb begin
    logic [brb_pkg::LEN_W-1:0] sel;
    data_next = '0;
    for (int i = 0; i < brb_pkg::MAX_LANES; i++) begin
      sel = brb_pkg::LEN_W'(meta.lane) + brb_pkg::LEN_W'(i);
      if (sel >= brb_pkg::LEN_W'(LANES)) begin
        sel = sel - brb_pkg::LEN_W'(LANES);
      end
      if (meta.ok && meta.rd && (brb_pkg::LEN_W'(i) < meta.len)) begin
        data_next[i*brb_pkg::BYTE_W +: brb_pkg::BYTE_W] = rb[sel[SEL_W-1:0]];
      end
    end
  end

  assign take = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_valid) begin
      accepted   <= meta.ok;
      data_out   <= data_next;
      fill_level <= meta.fill;
    end
  end
endmodule
`default_nettype wire

/* sim/tb_byte_ring_buffer_chunked_unit.sv */
// Testbench of the chunked byte ring buffer: queued driver, checking monitor, ring predictor
`default_nettype none
module tb_byte_ring_buffer_chunked_unit;
  localparam logic [brb_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int CLK_HALF = 6;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [brb_pkg::OP_W-1:0]   op;
    logic [brb_pkg::LEN_W-1:0]  len;
    logic [brb_pkg::DATA_W-1:0] data;
  } chunk_item_t;

  typedef struct {
    logic                       acc;
    logic [brb_pkg::DATA_W-1:0] data;
    logic [brb_pkg::FILL_W-1:0] fill;
  } ring_rsp_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [brb_pkg::OP_W-1:0]     op;
  logic [brb_pkg::LEN_W-1:0]    length;
  logic [brb_pkg::DATA_W-1:0]   data_in;
  logic                         out_valid;
  logic                         out_stall;
  logic                         accepted;
  logic [brb_pkg::DATA_W-1:0]   data_out;
  logic [brb_pkg::FILL_W-1:0]   fill_level;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [brb_pkg::CAP_W-1:0]    capacity;

  byte_ring_buffer_chunked_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .length     (length),
    .data_in    (data_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted),
    .data_out   (data_out),
    .fill_level (fill_level),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity)
  );

  // predicted ring state
  logic [brb_pkg::BYTE_W-1:0] ring_mem [0:brb_pkg::DEPTH_DEFAULT-1];
  int unsigned ring_cap;
  int unsigned ring_rd;
  int unsigned ring_wr;
  int unsigned ring_cnt;

  chunk_item_t chunk_q[$];
  ring_rsp_t   expected_rsp_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int items_taken = 0;
  int results_seen = 0;
  int accepted_seen = 0;
  int cap_writes = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int unsigned ring_next(int unsigned p);
    return (p + 1 >= ring_cap) ? 0 : p + 1;
  endfunction

  function automatic void ring_access(logic [brb_pkg::OP_W-1:0] op_v,
                                      logic [brb_pkg::LEN_W-1:0] len_v,
                                      logic [brb_pkg::DATA_W-1:0] d);
    ring_rsp_t r;
    int unsigned p;
    int unsigned len_u;
    r.acc = 1'b0;
    r.data = '0;
    len_u = 32'(len_v);
    if (len_u <= brb_pkg::MAX_LANES) begin
      if (op_v == brb_pkg::OP_WRITE) begin
        if (ring_cap != 0 && len_u + ring_cnt <= ring_cap) begin
          p = ring_wr;
          for (int i = 0; i < len_u; i++) begin
            ring_mem[p] = d[8*i +: 8];
            p = ring_next(p);
          end
          ring_wr = p;
          ring_cnt += len_u;
          r.acc = 1'b1;
        end
      end else if (op_v == brb_pkg::OP_READ || op_v == brb_pkg::OP_PEEK) begin
        if (len_u <= ring_cnt) begin
          p = ring_rd;
          for (int i = 0; i < len_u; i++) begin
            r.data[8*i +: 8] = ring_mem[p];
            p = ring_next(p);
          end
          if (op_v == brb_pkg::OP_READ) begin
            ring_rd = p;
            ring_cnt -= len_u;
          end
          r.acc = 1'b1;
        end
      end
    end
    r.fill = ring_cnt[brb_pkg::FILL_W-1:0];
    expected_rsp_q.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin : drive_proc
    chunk_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ring_access(op, length, data_in);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (chunk_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = chunk_q.pop_front();
          in_valid <= 1'b1;
          op <= it.op;
          length <= it.len;
          data_in <= it.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_proc
    ring_rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected result: accepted %0d data_out %h fill_level %0d",
               accepted, data_out, fill_level);
        err_count++;
      end else begin
        e = expected_rsp_q.pop_front();
        if (e.acc) accepted_seen++;
        if (accepted !== e.acc) begin
          $error("accepted: expected %0d, got %0d", e.acc, accepted);
          err_count++;
        end
        if (data_out !== e.data) begin
          $error("data_out: expected %h, got %h", e.data, data_out);
          err_count++;
        end
        if (fill_level !== e.fill) begin
          $error("fill_level: expected %0d, got %0d", e.fill, fill_level);
          err_count++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic wait_drained();
    do @(posedge clk); while (chunk_q.size() != 0 || in_valid || expected_rsp_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [brb_pkg::CAP_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    capacity <= v;
    do @(posedge clk); while (!cfg_ready);
    ring_cap = (32'(v) > brb_pkg::DEPTH_DEFAULT) ? brb_pkg::DEPTH_DEFAULT : 32'(v);
    ring_rd = 0;
    ring_wr = 0;
    ring_cnt = 0;
    cap_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(idle_mode_t m);
    send_idle_pct  = (m == IDLE_SEND) ? 67 : (m == IDLE_BOTH) ? 29 : 0;
    recv_stall_pct = (m == IDLE_RECV) ? 67 : (m == IDLE_BOTH) ? 29 : 0;
  endtask

  task automatic push_item(logic [brb_pkg::OP_W-1:0] op_v, logic [brb_pkg::LEN_W-1:0] len_v,
                           logic [brb_pkg::DATA_W-1:0] d);
    chunk_item_t it;
    it.op = op_v;
    it.len = len_v;
    it.data = d;
    chunk_q.push_back(it);
  endtask

  task automatic run_phase(logic [brb_pkg::CAP_W-1:0] cap, idle_mode_t m, int n, int wpct);
    logic [brb_pkg::OP_W-1:0]  op_v;
    logic [brb_pkg::LEN_W-1:0] len_v;
    int r;
    set_capacity(cap);
    set_idling(m);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op_v = OP_UNKNOWN;
        len_v = brb_pkg::LEN_W'($urandom_range(0, 15));
      end else if (r < 8) begin
        op_v = brb_pkg::OP_W'($urandom_range(0, 2));
        len_v = brb_pkg::LEN_W'($urandom_range(brb_pkg::MAX_LANES + 1, 15));
      end else begin
        if ($urandom_range(0, 99) < wpct) op_v = brb_pkg::OP_WRITE;
        else op_v = ($urandom_range(0, 2) == 0) ? brb_pkg::OP_PEEK : brb_pkg::OP_READ;
        len_v = ($urandom_range(0, 3) == 0) ? brb_pkg::LEN_W'(brb_pkg::MAX_LANES) :
                brb_pkg::LEN_W'($urandom_range(0, brb_pkg::MAX_LANES));
      end
      push_item(op_v, len_v, {$urandom, $urandom});
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= brb_pkg::OP_WRITE;
    length <= '0;
    data_in <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    capacity <= '0;
    ring_cap = brb_pkg::CAP_RESET;
    ring_rd = 0;
    ring_wr = 0;
    ring_cnt = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: empty reads, full-width chunks
    set_idling(IDLE_NONE);
    push_item(brb_pkg::OP_READ, 4'd1, '0);
    push_item(brb_pkg::OP_PEEK, 4'd0, '0);
    push_item(brb_pkg::OP_WRITE, 4'd8, '1);
    push_item(brb_pkg::OP_WRITE, 4'd8, '0);
    push_item(brb_pkg::OP_PEEK, 4'd8, '0);
    push_item(brb_pkg::OP_READ, 4'd8, '0);
    push_item(brb_pkg::OP_READ, 4'd8, '0);

    // no buffer
    set_capacity(11'd0);
    push_item(brb_pkg::OP_WRITE, 4'd0, '1);
    push_item(brb_pkg::OP_WRITE, 4'd1, '1);
    push_item(brb_pkg::OP_READ, 4'd0, '0);

    // tiny ring: full, refused, wrap, bad length, unknown op
    set_capacity(11'd9);
    push_item(brb_pkg::OP_WRITE, 4'd8, 64'hf0e1_d2c3_b4a5_9687);
    push_item(brb_pkg::OP_WRITE, 4'd2, '1);
    push_item(brb_pkg::OP_WRITE, 4'd1, 64'h5a);
    push_item(brb_pkg::OP_PEEK, 4'd8, '0);
    push_item(brb_pkg::OP_READ, 4'd8, '0);
    push_item(brb_pkg::OP_READ, 4'd2, '0);
    push_item(brb_pkg::OP_WRITE, 4'd8, 64'h0123_4567_89ab_cdef);
    push_item(brb_pkg::OP_READ, 4'd9, '0);
    push_item(OP_UNKNOWN, 4'd4, '1);
    push_item(brb_pkg::OP_WRITE, 4'd15, '1);
    push_item(brb_pkg::OP_PEEK, 4'd0, '0);
    push_item(brb_pkg::OP_READ, 4'd8, '0);

    run_phase(11'd8, IDLE_NONE, 120, 50);
    run_phase(11'd1, IDLE_SEND, 100, 50);
    run_phase(11'h7ff, IDLE_RECV, 300, 90);
    run_phase(11'd0, IDLE_BOTH, 60, 50);
    run_phase(11'd13, IDLE_BOTH, 150, 55);
    run_phase(brb_pkg::CAP_W'($urandom_range(2, brb_pkg::DEPTH_DEFAULT - 1)), IDLE_SEND,
              150, 60);
    run_phase(brb_pkg::CAP_W'(brb_pkg::CAP_RESET), IDLE_RECV, 150, 50);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("ran %0d items over %0d capacity settings and four idling modes", items_taken,
             cap_writes);
    $display("checked %0d results, %0d of them accepted accesses", results_seen, accepted_seen);
    if (err_count == 0 && expected_rsp_q.size() == 0) begin
      $display("tb_byte_ring_buffer_chunked_unit: done, clean");
    end else begin
      $display("tb_byte_ring_buffer_chunked_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("tb_byte_ring_buffer_chunked_unit: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/brb_pkg.sv
rtl/brb_ram.sv
rtl/brb_lane.sv
rtl/brb_merge.sv
rtl/byte_ring_buffer_chunked_unit.sv
sim/tb_byte_ring_buffer_chunked_unit.sv
